[src/ctok_pkg.sv]
// Package for the C-subset tokenizer: token kinds, error codes, scanner modes
// and character and keyword helpers. It has no dependencies.
`default_nettype none

package ctok_pkg;

  localparam logic [5:0] KIND_NONE    = 6'd0;
  localparam logic [5:0] KIND_PLUS    = 6'd1;
  localparam logic [5:0] KIND_MINUS   = 6'd2;
  localparam logic [5:0] KIND_MUL     = 6'd3;
  localparam logic [5:0] KIND_DIV     = 6'd4;
  localparam logic [5:0] KIND_LT      = 6'd5;
  localparam logic [5:0] KIND_LE      = 6'd6;
  localparam logic [5:0] KIND_GE      = 6'd7;
  localparam logic [5:0] KIND_GT      = 6'd8;
  localparam logic [5:0] KIND_NE      = 6'd9;
  localparam logic [5:0] KIND_EQEQ    = 6'd10;
  localparam logic [5:0] KIND_ASSIGN  = 6'd11;
  localparam logic [5:0] KIND_LPAREN  = 6'd12;
  localparam logic [5:0] KIND_RPAREN  = 6'd13;
  localparam logic [5:0] KIND_LBRACK  = 6'd14;
  localparam logic [5:0] KIND_RBRACK  = 6'd15;
  localparam logic [5:0] KIND_LBRACE  = 6'd16;
  localparam logic [5:0] KIND_RBRACE  = 6'd17;
  localparam logic [5:0] KIND_COMMA   = 6'd18;
  localparam logic [5:0] KIND_SEMI    = 6'd19;
  localparam logic [5:0] KIND_IDENT   = 6'd20;
  localparam logic [5:0] KIND_UINT    = 6'd21;
  localparam logic [5:0] KIND_ZERO    = 6'd22;
  localparam logic [5:0] KIND_CHAR    = 6'd23;
  localparam logic [5:0] KIND_STRING  = 6'd24;
  localparam logic [5:0] KIND_MAIN    = 6'd25;
  localparam logic [5:0] KIND_INT     = 6'd26;
  localparam logic [5:0] KIND_KCHAR   = 6'd27;
  localparam logic [5:0] KIND_CONST   = 6'd28;
  localparam logic [5:0] KIND_VOID    = 6'd29;
  localparam logic [5:0] KIND_IF      = 6'd30;
  localparam logic [5:0] KIND_ELSE    = 6'd31;
  localparam logic [5:0] KIND_DO      = 6'd32;
  localparam logic [5:0] KIND_WHILE   = 6'd33;
  localparam logic [5:0] KIND_FOR     = 6'd34;
  localparam logic [5:0] KIND_SCANF   = 6'd35;
  localparam logic [5:0] KIND_PRINTF  = 6'd36;
  localparam logic [5:0] KIND_RETURN  = 6'd37;
  localparam logic [5:0] KIND_UNKNOWN = 6'd38;

  localparam logic [3:0] ERR_OK           = 4'd0;
  localparam logic [3:0] ERR_LEAD_ZERO    = 4'd1;
  localparam logic [3:0] ERR_LETTER_NUM   = 4'd2;
  localparam logic [3:0] ERR_CHAR_UNCLOSED = 4'd3;
  localparam logic [3:0] ERR_CHAR_BAD     = 4'd4;
  localparam logic [3:0] ERR_STR_ILLEGAL  = 4'd5;
  localparam logic [3:0] ERR_STR_UNTERM   = 4'd6;
  localparam logic [3:0] ERR_LONE_BANG    = 4'd7;
  localparam logic [3:0] ERR_TRUNC        = 4'd8;

  // Scanner modes, one-hot.
  typedef enum logic [12:0] {
    M_IDLE       = 13'b0000000000001,
    M_IDENT      = 13'b0000000000010,
    M_ZERO       = 13'b0000000000100,
    M_NUMBER     = 13'b0000000001000,
    M_DRAIN      = 13'b0000000010000,
    M_CHAR_OPEN  = 13'b0000000100000,
    M_CHAR_CLOSE = 13'b0000001000000,
    M_STRING     = 13'b0000010000000,
    M_STRING_SKIP = 13'b0000100000000,
    M_LT         = 13'b0001000000000,
    M_GT         = 13'b0010000000000,
    M_BANG       = 13'b0100000000000,
    M_EQ         = 13'b1000000000000
  } scan_mode_e;

  function automatic logic is_letter(input logic [7:0] c);
    return (c >= "A" && c <= "Z") || (c >= "a" && c <= "z") || c == "_";
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  // Keyword lookup on the first six text bytes (first byte in the low bits).
  // Returns KIND_NONE when the word is no keyword.
  function automatic logic [5:0] keyword_kind(input logic [47:0] w, input logic [2:0] n);
    logic [5:0] k;
    k = KIND_NONE;
    case (n)
      3'd2: begin
        if (w[15:0] == "fi") k = KIND_IF;
        if (w[15:0] == "od") k = KIND_DO;
      end
      3'd3: begin
        if (w[23:0] == "tni") k = KIND_INT;
        if (w[23:0] == "rof") k = KIND_FOR;
      end
      3'd4: begin
        if (w[31:0] == "niam") k = KIND_MAIN;
        if (w[31:0] == "rahc") k = KIND_KCHAR;
        if (w[31:0] == "diov") k = KIND_VOID;
        if (w[31:0] == "esle") k = KIND_ELSE;
      end
      3'd5: begin
        if (w[39:0] == "tsnoc") k = KIND_CONST;
        if (w[39:0] == "elihw") k = KIND_WHILE;
        if (w[39:0] == "fnacs") k = KIND_SCANF;
      end
      3'd6: begin
        if (w[47:0] == "ftnirp") k = KIND_PRINTF;
        if (w[47:0] == "nruter") k = KIND_RETURN;
      end
      default: k = KIND_NONE;
    endcase
    return k;
  endfunction

endpackage

`default_nettype wire

[src/ctok_fifo.sv]
// Small token queue between the scanner and the chunk emitter.
// Flop storage with the head read combinationally; no package dependencies.
`default_nettype none

module ctok_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  wire logic [WIDTH-1:0] data_i,
  input  wire logic             pop_i,
  output logic      [WIDTH-1:0] data_o,
  output logic                  full_o,
  output logic                  empty_o
);
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [DEPTH-1:0][WIDTH-1:0] mem_q;
  logic [AW:0] wr_q, wr_d, rd_q, rd_d;

  assign empty_o = (wr_q == rd_q);
  assign full_o  = (wr_q[AW-1:0] == rd_q[AW-1:0]) && (wr_q[AW] != rd_q[AW]);
  assign data_o  = mem_q[rd_q[AW-1:0]];

  // Pointer update.
  always_comb begin
    wr_d = wr_q + (AW+1)'(push_i);
    rd_d = rd_q + (AW+1)'(pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q <= '0;
      rd_q <= '0;
    end else begin
      wr_q <= wr_d;
      rd_q <= rd_d;
    end
  end

  // Entry storage.
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q[AW-1:0]] <= data_i;
    end
  end

  property p_no_overflow;
    @(posedge clk_i) disable iff (!rst_ni) push_i |-> !full_o;
  endproperty
  assert property (p_no_overflow) else $error("token queue overflow");

  property p_no_underflow;
    @(posedge clk_i) disable iff (!rst_ni) pop_i |-> !empty_o;
  endproperty
  assert property (p_no_underflow) else $error("token queue underflow");

  property p_count_bound;
    @(posedge clk_i) disable iff (!rst_ni) (AW+1)'(wr_q - rd_q) <= (AW+1)'(DEPTH);
  endproperty
  assert property (p_count_bound) else $error("token queue count out of range");

endmodule

`default_nettype wire

[src/ctok_front.sv]
// Scanner front end: classifies one source byte per accepted request and
// queues finished tokens. Depends on ctok_pkg.
`default_nettype none

module ctok_front #(
  parameter int MAX_TOKEN_LEN = 32,
  parameter int LW = $clog2(MAX_TOKEN_LEN + 1),
  parameter int EW = 1 + 6 + 4 + LW + 8 * MAX_TOKEN_LEN + 1 + 6 + 8
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          accept_i,
  input  wire logic [7:0]    char_i,
  input  wire logic          eot_i,
  output logic               push_o,
  output logic [EW-1:0]      entry_o
);
  import ctok_pkg::*;

  localparam int IW = $clog2(MAX_TOKEN_LEN);
  localparam int TW = 8 * MAX_TOKEN_LEN;

  scan_mode_e mode_q, mode_d;
  logic [MAX_TOKEN_LEN-1:0][7:0] text_q;
  logic [LW-1:0] len_q, len_d, base_len;
  logic [3:0] pend_q, pend_d;
  logic trunc_q, trunc_d, base_trunc;

  logic eot, letter, digit, alnum, blank;
  logic rescan, start, app, wr_en;
  logic pv, psrc_buf, sv, sv_keep;
  logic [5:0] pkind, skind, kw;
  logic [3:0] perr, tok_err;
  logic [7:0] pa, pb;
  logic [1:0] ptxt_len;
  logic [LW-1:0] plen;
  logic [TW-1:0] ptext;

  assign eot    = eot_i || (char_i == 8'd0);
  assign letter = !eot && is_letter(char_i);
  assign digit  = !eot && is_digit(char_i);
  assign alnum  = letter || digit;
  assign blank  = (char_i == " ") || (char_i == 8'h0a) || (char_i == 8'h09);
  assign kw     = keyword_kind(text_q[5:0], (len_q <= LW'(6)) ? len_q[2:0] : 3'd0);
  assign tok_err = trunc_q ? ERR_TRUNC : ERR_OK;

  // Mode step, token ends and restart on the terminating byte.
  always_comb begin
    mode_d = mode_q;
    pend_d = pend_q;
    rescan = 1'b0;
    start = 1'b0;
    app = 1'b0;
    pv = 1'b0;
    psrc_buf = 1'b0;
    pkind = KIND_NONE;
    perr = ERR_OK;
    pa = 8'd0;
    pb = 8'd0;
    ptxt_len = 2'd0;
    sv = 1'b0;
    skind = KIND_UNKNOWN;
    unique case (mode_q)
      M_IDENT: begin
        if (alnum) begin
          app = 1'b1;
        end else begin
          pv = 1'b1; psrc_buf = 1'b1;
          pkind = (trunc_q || kw == KIND_NONE) ? KIND_IDENT : kw;
          perr = tok_err;
          rescan = 1'b1;
        end
      end
      M_ZERO: begin
        if (alnum) begin
          pend_d = digit ? ERR_LEAD_ZERO : ERR_LETTER_NUM;
          mode_d = M_DRAIN;
        end else begin
          pv = 1'b1; psrc_buf = 1'b1; pkind = KIND_ZERO; perr = tok_err;
          rescan = 1'b1;
        end
      end
      M_NUMBER: begin
        if (digit) begin
          app = 1'b1;
        end else if (alnum) begin
          pend_d = ERR_LETTER_NUM;
          mode_d = M_DRAIN;
        end else begin
          pv = 1'b1; psrc_buf = 1'b1; pkind = KIND_UINT; perr = tok_err;
          rescan = 1'b1;
        end
      end
      M_DRAIN: begin
        if (!alnum) begin
          pv = 1'b1; perr = pend_q;
          pend_d = ERR_OK;
          rescan = 1'b1;
        end
      end
      M_CHAR_OPEN: begin
        if (alnum || (!eot && (char_i == "+" || char_i == "-" ||
                               char_i == "*" || char_i == "/"))) begin
          start = 1'b1; app = 1'b1;
          mode_d = M_CHAR_CLOSE;
        end else begin
          pv = 1'b1; perr = ERR_CHAR_BAD;
          rescan = 1'b1;
        end
      end
      M_CHAR_CLOSE: begin
        pv = 1'b1; psrc_buf = 1'b1; pkind = KIND_CHAR;
        if (!eot && char_i == "'") begin
          perr = tok_err;
          mode_d = M_IDLE;
        end else begin
          perr = ERR_CHAR_UNCLOSED;
          rescan = 1'b1;
        end
      end
      M_STRING: begin
        if (eot) begin
          pv = 1'b1; perr = ERR_STR_UNTERM;
          mode_d = M_IDLE;
        end else if (char_i == "\"") begin
          pv = 1'b1; psrc_buf = 1'b1; pkind = KIND_STRING; perr = tok_err;
          mode_d = M_IDLE;
        end else if (char_i >= 8'd32 && char_i <= 8'd126) begin
          app = 1'b1;
        end else begin
          pv = 1'b1; perr = ERR_STR_ILLEGAL;
          mode_d = M_STRING_SKIP;
        end
      end
      M_STRING_SKIP: begin
        if (eot || char_i == "\"") mode_d = M_IDLE;
      end
      M_LT: begin
        pv = 1'b1; pa = "<";
        if (!eot && char_i == "=") begin
          pkind = KIND_LE; pb = "="; ptxt_len = 2'd2; mode_d = M_IDLE;
        end else begin
          pkind = KIND_LT; ptxt_len = 2'd1; rescan = 1'b1;
        end
      end
      M_GT: begin
        pv = 1'b1; pa = ">";
        if (!eot && char_i == "=") begin
          pkind = KIND_GE; pb = "="; ptxt_len = 2'd2; mode_d = M_IDLE;
        end else begin
          pkind = KIND_GT; ptxt_len = 2'd1; rescan = 1'b1;
        end
      end
      M_BANG: begin
        pv = 1'b1;
        if (!eot && char_i == "=") begin
          pkind = KIND_NE; pa = "!"; pb = "="; ptxt_len = 2'd2; mode_d = M_IDLE;
        end else begin
          perr = ERR_LONE_BANG; rescan = 1'b1;
        end
      end
      M_EQ: begin
        pv = 1'b1; pa = "=";
        if (!eot && char_i == "=") begin
          pkind = KIND_EQEQ; pb = "="; ptxt_len = 2'd2; mode_d = M_IDLE;
        end else begin
          pkind = KIND_ASSIGN; ptxt_len = 2'd1; rescan = 1'b1;
        end
      end
      default: begin
        rescan = 1'b1;
      end
    endcase

    // The terminating byte starts the next token from idle.
    if (rescan) begin
      mode_d = M_IDLE;
      if (!eot && !blank) begin
        if (letter) begin
          start = 1'b1; app = 1'b1; mode_d = M_IDENT;
        end else if (digit) begin
          start = 1'b1; app = 1'b1;
          mode_d = (char_i == "0") ? M_ZERO : M_NUMBER;
        end else begin
          case (char_i)
            "'":  mode_d = M_CHAR_OPEN;
            "\"": begin start = 1'b1; mode_d = M_STRING; end
            "<":  mode_d = M_LT;
            ">":  mode_d = M_GT;
            "!":  mode_d = M_BANG;
            "=":  mode_d = M_EQ;
            "+":  begin sv = 1'b1; skind = KIND_PLUS; end
            "-":  begin sv = 1'b1; skind = KIND_MINUS; end
            "*":  begin sv = 1'b1; skind = KIND_MUL; end
            "/":  begin sv = 1'b1; skind = KIND_DIV; end
            "(":  begin sv = 1'b1; skind = KIND_LPAREN; end
            ")":  begin sv = 1'b1; skind = KIND_RPAREN; end
            "[":  begin sv = 1'b1; skind = KIND_LBRACK; end
            "]":  begin sv = 1'b1; skind = KIND_RBRACK; end
            "{":  begin sv = 1'b1; skind = KIND_LBRACE; end
            "}":  begin sv = 1'b1; skind = KIND_RBRACE; end
            ",":  begin sv = 1'b1; skind = KIND_COMMA; end
            ";":  begin sv = 1'b1; skind = KIND_SEMI; end
            default: begin sv = 1'b1; skind = KIND_UNKNOWN; end
          endcase
        end
      end
    end
  end

  // Text buffer append, truncating at the maximum length.
  always_comb begin
    base_len   = start ? '0 : len_q;
    base_trunc = start ? 1'b0 : trunc_q;
    len_d      = base_len;
    trunc_d    = base_trunc;
    wr_en      = 1'b0;
    if (app) begin
      if (int'(base_len) < MAX_TOKEN_LEN) begin
        wr_en = 1'b1;
        len_d = base_len + LW'(1);
      end else begin
        trunc_d = 1'b1;
      end
    end
  end

  // Queue entry: primary token from the buffer or a short spelling, then an
  // optional one-character token, dropped when the primary is over 32 bytes.
  always_comb begin
    ptext = psrc_buf ? TW'(text_q) : TW'({pb, pa});
    plen  = psrc_buf ? len_q : LW'(ptxt_len);
    sv_keep = sv && !(pv && (int'(plen) > 32));
    entry_o = {char_i, skind, sv_keep, ptext, plen, perr, pkind, pv};
    push_o  = accept_i && (pv || sv_keep);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= M_IDLE;
      len_q   <= '0;
      pend_q  <= ERR_OK;
      trunc_q <= 1'b0;
    end else if (accept_i) begin
      mode_q  <= mode_d;
      len_q   <= len_d;
      pend_q  <= pend_d;
      trunc_q <= trunc_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_i && wr_en) begin
      text_q[base_len[IW-1:0]] <= char_i;
    end
  end

  property p_len_bound;
    @(posedge clk_i) disable iff (!rst_ni) int'(len_q) <= MAX_TOKEN_LEN;
  endproperty
  assert property (p_len_bound) else $error("token length beyond buffer");

  property p_trunc_full;
    @(posedge clk_i) disable iff (!rst_ni) trunc_q |-> int'(len_q) == MAX_TOKEN_LEN;
  endproperty
  assert property (p_trunc_full) else $error("truncated with room left");

  property p_drain_pending;
    @(posedge clk_i) disable iff (!rst_ni)
      (mode_q == M_DRAIN) |-> (pend_q == ERR_LEAD_ZERO || pend_q == ERR_LETTER_NUM);
  endproperty
  assert property (p_drain_pending) else $error("drain without pending error");

endmodule

`default_nettype wire

[src/ctok_back.sv]
// Chunk emitter back end: turns queued tokens into 8-byte result items and
// holds them in the output register. Depends on ctok_pkg.
`default_nettype none

module ctok_back #(
  parameter int MAX_TOKEN_LEN = 32,
  parameter int LW = $clog2(MAX_TOKEN_LEN + 1),
  parameter int EW = 1 + 6 + 4 + LW + 8 * MAX_TOKEN_LEN + 1 + 6 + 8
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic [EW-1:0] entry_i,
  input  wire logic          empty_i,
  output logic               pop_o,
  output logic               valid_o,
  input  wire logic          ready_i,
  output logic [5:0]         kind_o,
  output logic [3:0]         err_o,
  output logic [63:0]        chunk_o,
  output logic [3:0]         bytes_o,
  output logic [1:0]         index_o,
  output logic               last_o
);
  import ctok_pkg::*;

  localparam int TW  = 8 * MAX_TOKEN_LEN;
  localparam int NCH = (MAX_TOKEN_LEN + 7) / 8;
  localparam int NCP = (NCH > 8) ? NCH : 8;
  localparam int XW  = LW + 4;

  logic h_pv, h_sv;
  logic [5:0] h_kind, h_skind;
  logic [3:0] h_err;
  logic [LW-1:0] h_len;
  logic [TW-1:0] h_text;
  logic [7:0] h_char;
  logic [NCP-1:0][63:0] tpad;

  logic [2:0] j_q, j_d;
  logic sec_q, sec_d;
  logic ov_q;
  logic [5:0] kind_q, kind_d;
  logic [3:0] err_q, err_d, bytes_q, bytes_d;
  logic [63:0] chunk_q, chunk_d, raw;
  logic [1:0] idx_q, idx_d;
  logic last_q, last_d;

  logic cur_sec, fire, prim_done;
  logic [XW-1:0] off, rem, nch, lim;

  assign {h_char, h_skind, h_sv, h_text, h_len, h_err, h_kind, h_pv} = entry_i;
  assign tpad = (NCP * 64)'(h_text);

  assign cur_sec = sec_q || !h_pv;
  assign fire    = !empty_i && (!ov_q || ready_i);

  // Item build for the current chunk of the head token.
  always_comb begin
    off = XW'(j_q) << 3;
    rem = XW'(h_len) - off;
    nch = (h_len == '0) ? XW'(1) : ((XW'(h_len) + XW'(7)) >> 3);
    lim = (nch > XW'(5)) ? XW'(5) : nch;
    prim_done = (XW'(j_q) + XW'(1)) >= lim;
    raw = tpad[j_q];
    if (cur_sec) begin
      kind_d  = h_skind;
      err_d   = ERR_OK;
      chunk_d = 64'(h_char);
      bytes_d = 4'd1;
      idx_d   = 2'd0;
      last_d  = 1'b1;
    end else begin
      kind_d  = h_kind;
      err_d   = h_err;
      bytes_d = (rem >= XW'(8)) ? 4'd8 : rem[3:0];
      idx_d   = j_q[1:0];
      last_d  = (off + XW'(8)) >= XW'(h_len);
      for (int b = 0; b < 8; b++) begin
        chunk_d[8*b +: 8] = (4'(b) < bytes_d) ? raw[8*b +: 8] : 8'd0;
      end
    end
  end

  // Walk through the chunks, then the trailing one-character token.
  always_comb begin
    j_d = j_q;
    sec_d = sec_q;
    pop_o = 1'b0;
    if (fire) begin
      if (cur_sec) begin
        pop_o = 1'b1; sec_d = 1'b0; j_d = 3'd0;
      end else if (!prim_done) begin
        j_d = j_q + 3'd1;
      end else if (h_sv) begin
        sec_d = 1'b1; j_d = 3'd0;
      end else begin
        pop_o = 1'b1; j_d = 3'd0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      j_q   <= 3'd0;
      sec_q <= 1'b0;
      ov_q  <= 1'b0;
    end else begin
      j_q   <= j_d;
      sec_q <= sec_d;
      if (fire) begin
        ov_q <= 1'b1;
      end else if (ready_i) begin
        ov_q <= 1'b0;
      end
    end
  end

  // Output register payload.
  always_ff @(posedge clk_i) begin
    if (fire) begin
      kind_q  <= kind_d;
      err_q   <= err_d;
      chunk_q <= chunk_d;
      bytes_q <= bytes_d;
      idx_q   <= idx_d;
      last_q  <= last_d;
    end
  end

  assign valid_o = ov_q;
  assign kind_o  = kind_q;
  assign err_o   = err_q;
  assign chunk_o = chunk_q;
  assign bytes_o = bytes_q;
  assign index_o = idx_q;
  assign last_o  = last_q;

  property p_error_item;
    @(posedge clk_i) disable iff (!rst_ni)
      (ov_q && kind_q == KIND_NONE) |-> (bytes_q == 4'd0 && last_q && err_q != ERR_OK);
  endproperty
  assert property (p_error_item) else $error("malformed error item");

  property p_bytes_bound;
    @(posedge clk_i) disable iff (!rst_ni) ov_q |-> bytes_q <= 4'd8;
  endproperty
  assert property (p_bytes_bound) else $error("chunk byte count too large");

  property p_chunk_cap;
    @(posedge clk_i) disable iff (!rst_ni) j_q <= 3'd4;
  endproperty
  assert property (p_chunk_cap) else $error("more than five chunks in a step");

endmodule

`default_nettype wire

[src/c_subset_tokenizer.sv]
// C-subset tokenizer. Takes one source byte per request on the slave stream
// (tlast flags end of text) and returns token items on the master stream:
// kind in tuser, text in 8-byte chunks in tdata, tlast on a token's last item.
// The scanner accepts one byte every cycle while not held off; its tokens wait in a
// QUEUE_DEPTH entry queue, and the emitter sends one result item per cycle from its
// output register while the consumer is ready, so a token of n text bytes gives
// max(1, ceil(n/8)) items. Input is held off only while the queue is full, which
// happens when results are produced faster than one per byte or the consumer stalls.
// Depends on ctok_pkg, ctok_front, ctok_fifo and ctok_back.
`default_nettype none

module c_subset_tokenizer #(
  parameter int MAX_TOKEN_LEN = 32,
  parameter int QUEUE_DEPTH = 4
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,   // [7:0] char_code
  input  wire logic        s_axis_tlast,   // end_of_input
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [79:0]      m_axis_tdata,   // [3:0] error_code, [67:4] text_chunk,
                                           // [71:68] chunk_bytes, [73:72] chunk_index
  output logic [5:0]       m_axis_tuser,   // [5:0] token_kind
  output logic             m_axis_tlast    // last_chunk
);
  localparam int LW = $clog2(MAX_TOKEN_LEN + 1);
  localparam int EW = 1 + 6 + 4 + LW + 8 * MAX_TOKEN_LEN + 1 + 6 + 8;

  logic accept, push, pop, full, empty;
  logic [EW-1:0] wr_entry, rd_entry;
  logic [3:0] err, bytes;
  logic [63:0] chunk;
  logic [1:0] idx;

  assign s_axis_tready = !full;
  assign accept = s_axis_tvalid && s_axis_tready;

  ctok_front #(.MAX_TOKEN_LEN(MAX_TOKEN_LEN), .LW(LW), .EW(EW)) u_front (
    .clk_i, .rst_ni,
    .accept_i(accept), .char_i(s_axis_tdata), .eot_i(s_axis_tlast),
    .push_o(push), .entry_o(wr_entry)
  );

  ctok_fifo #(.WIDTH(EW), .DEPTH(QUEUE_DEPTH)) u_queue (
    .clk_i, .rst_ni,
    .push_i(push), .data_i(wr_entry), .pop_i(pop),
    .data_o(rd_entry), .full_o(full), .empty_o(empty)
  );

  ctok_back #(.MAX_TOKEN_LEN(MAX_TOKEN_LEN), .LW(LW), .EW(EW)) u_back (
    .clk_i, .rst_ni,
    .entry_i(rd_entry), .empty_i(empty), .pop_o(pop),
    .valid_o(m_axis_tvalid), .ready_i(m_axis_tready),
    .kind_o(m_axis_tuser), .err_o(err), .chunk_o(chunk),
    .bytes_o(bytes), .index_o(idx), .last_o(m_axis_tlast)
  );

  assign m_axis_tdata = {6'd0, idx, bytes, chunk, err};

endmodule

`default_nettype wire

[tb/sv/tb_c_subset_tokenizer.sv]
// Testbench for the C-subset tokenizer: streams source bytes in, predicts every token item
// in a behavioral scanner model and checks the output stream field by field.
// Depends on ctok_pkg and c_subset_tokenizer.
`timescale 1ns / 1ps

module tb_c_subset_tokenizer;
  import ctok_pkg::*;

  localparam int MaxLen = 32;
  localparam int WatchLimit = 20000;

  typedef struct packed {
    logic [5:0]  kind;
    logic [3:0]  err;
    logic [63:0] chunk;
    logic [3:0]  nbytes;
    logic [1:0]  idx;
    logic        last;
  } tok_item_t;

  typedef struct packed {
    logic [7:0] ch;
    logic       eot;
    logic       hold;   // wait for every expected token before sending
  } src_byte_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [7:0] s_axis_tdata = '0;
  logic s_axis_tlast = 1'b0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [79:0] m_axis_tdata;
  logic [5:0] m_axis_tuser;
  logic m_axis_tlast;

  c_subset_tokenizer dut (
    .clk_i, .rst_ni,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tlast,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser, .m_axis_tlast
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  src_byte_t pending_bytes[$];
  tok_item_t expected_tokens[$];
  int mismatches = 0;
  int tokens_seen = 0;
  int bytes_sent = 0;
  bit quiet_phase = 1'b0;
  int idle_cycles = 0;

  // Scanner model state.
  scan_mode_e mdl_mode = M_IDLE;
  logic [7:0] mdl_text[MaxLen];
  int mdl_len = 0;
  logic [3:0] mdl_pend = ERR_OK;
  bit mdl_trunc = 1'b0;

  function automatic bit letter_c(logic [7:0] c);
    return (c >= "A" && c <= "Z") || (c >= "a" && c <= "z") || c == "_";
  endfunction

  function automatic bit digit_c(logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic void push_item(logic [5:0] k, logic [3:0] e, logic [63:0] d,
                                    int n, int i, bit l);
    tok_item_t t;
    t.kind = k; t.err = e; t.chunk = d; t.nbytes = n[3:0]; t.idx = i[1:0]; t.last = l;
    expected_tokens.push_back(t);
  endfunction

  function automatic void add_char(logic [7:0] c);
    if (mdl_len < MaxLen) begin
      mdl_text[mdl_len] = c;
      mdl_len++;
    end else begin
      mdl_trunc = 1'b1;
    end
  endfunction

  function automatic void emit_tok(logic [5:0] k, logic [3:0] e);
    logic [63:0] d;
    int b;
    if (e == ERR_OK && mdl_trunc) e = ERR_TRUNC;
    if (mdl_len == 0) begin
      push_item(k, e, '0, 0, 0, 1'b1);
      return;
    end
    for (int s = 0; s < mdl_len; s += 8) begin
      d = '0;
      for (b = 0; b < 8 && s + b < mdl_len; b++) d[8*b +: 8] = mdl_text[s+b];
      push_item(k, e, d, b, s / 8, s + 8 >= mdl_len);
    end
  endfunction

  function automatic void emit_short(logic [5:0] k, logic [7:0] a, logic [7:0] b);
    mdl_len = 0; mdl_trunc = 1'b0;
    add_char(a);
    if (b != 0) add_char(b);
    emit_tok(k, ERR_OK);
  endfunction

  function automatic logic [5:0] word_kind();
    string w;
    w = "";
    if (mdl_trunc) return KIND_IDENT;
    for (int i = 0; i < mdl_len; i++) w = {w, string'(mdl_text[i])};
    case (w)
      "main": return KIND_MAIN;     "int": return KIND_INT;
      "char": return KIND_KCHAR;    "const": return KIND_CONST;
      "void": return KIND_VOID;     "if": return KIND_IF;
      "else": return KIND_ELSE;     "do": return KIND_DO;
      "while": return KIND_WHILE;   "for": return KIND_FOR;
      "scanf": return KIND_SCANF;   "printf": return KIND_PRINTF;
      "return": return KIND_RETURN;
      default: return KIND_IDENT;
    endcase
  endfunction

  function automatic void start_token(logic [7:0] c, bit eot);
    mdl_mode = M_IDLE;
    if (eot || c == " " || c == "\n" || c == "\t") return;
    if (letter_c(c)) begin
      mdl_len = 0; mdl_trunc = 1'b0; add_char(c); mdl_mode = M_IDENT; return;
    end
    if (digit_c(c)) begin
      mdl_len = 0; mdl_trunc = 1'b0; add_char(c);
      mdl_mode = (c == "0") ? M_ZERO : M_NUMBER;
      return;
    end
    case (c)
      "'": mdl_mode = M_CHAR_OPEN;
      "\"": begin mdl_len = 0; mdl_trunc = 1'b0; mdl_mode = M_STRING; end
      "<": mdl_mode = M_LT;
      ">": mdl_mode = M_GT;
      "!": mdl_mode = M_BANG;
      "=": mdl_mode = M_EQ;
      "+": emit_short(KIND_PLUS, c, 0);
      "-": emit_short(KIND_MINUS, c, 0);
      "*": emit_short(KIND_MUL, c, 0);
      "/": emit_short(KIND_DIV, c, 0);
      "(": emit_short(KIND_LPAREN, c, 0);
      ")": emit_short(KIND_RPAREN, c, 0);
      "[": emit_short(KIND_LBRACK, c, 0);
      "]": emit_short(KIND_RBRACK, c, 0);
      "{": emit_short(KIND_LBRACE, c, 0);
      "}": emit_short(KIND_RBRACE, c, 0);
      ",": emit_short(KIND_COMMA, c, 0);
      ";": emit_short(KIND_SEMI, c, 0);
      default: emit_short(KIND_UNKNOWN, c, 0);
    endcase
  endfunction

  // Advance the model by one accepted source byte.
  function automatic void scan_byte(logic [7:0] c, bit flag);
    bit eot, alnum, again;
    eot = flag || c == 0;
    alnum = !eot && (letter_c(c) || digit_c(c));
    again = 1'b0;
    case (mdl_mode)
      M_IDENT:
        if (alnum) add_char(c);
        else begin emit_tok(word_kind(), ERR_OK); again = 1'b1; end
      M_ZERO:
        if (alnum) begin
          mdl_pend = digit_c(c) ? ERR_LEAD_ZERO : ERR_LETTER_NUM; mdl_mode = M_DRAIN;
        end else begin emit_tok(KIND_ZERO, ERR_OK); again = 1'b1; end
      M_NUMBER:
        if (!eot && digit_c(c)) add_char(c);
        else if (alnum) begin mdl_pend = ERR_LETTER_NUM; mdl_mode = M_DRAIN; end
        else begin emit_tok(KIND_UINT, ERR_OK); again = 1'b1; end
      M_DRAIN:
        if (!alnum) begin
          push_item(KIND_NONE, mdl_pend, '0, 0, 0, 1'b1); mdl_pend = ERR_OK; again = 1'b1;
        end
      M_CHAR_OPEN:
        if (alnum || (!eot && (c == "+" || c == "-" || c == "*" || c == "/"))) begin
          mdl_len = 0; mdl_trunc = 1'b0; add_char(c); mdl_mode = M_CHAR_CLOSE;
        end else begin
          push_item(KIND_NONE, ERR_CHAR_BAD, '0, 0, 0, 1'b1); again = 1'b1;
        end
      M_CHAR_CLOSE:
        if (!eot && c == "'") begin emit_tok(KIND_CHAR, ERR_OK); mdl_mode = M_IDLE; end
        else begin emit_tok(KIND_CHAR, ERR_CHAR_UNCLOSED); again = 1'b1; end
      M_STRING:
        if (eot) begin
          push_item(KIND_NONE, ERR_STR_UNTERM, '0, 0, 0, 1'b1); mdl_mode = M_IDLE;
        end else if (c == "\"") begin
          emit_tok(KIND_STRING, ERR_OK); mdl_mode = M_IDLE;
        end else if (c >= 32 && c <= 126) begin
          add_char(c);
        end else begin
          push_item(KIND_NONE, ERR_STR_ILLEGAL, '0, 0, 0, 1'b1); mdl_mode = M_STRING_SKIP;
        end
      M_STRING_SKIP:
        if (eot || c == "\"") mdl_mode = M_IDLE;
      M_LT:
        if (!eot && c == "=") begin emit_short(KIND_LE, "<", "="); mdl_mode = M_IDLE; end
        else begin emit_short(KIND_LT, "<", 0); again = 1'b1; end
      M_GT:
        if (!eot && c == "=") begin emit_short(KIND_GE, ">", "="); mdl_mode = M_IDLE; end
        else begin emit_short(KIND_GT, ">", 0); again = 1'b1; end
      M_BANG:
        if (!eot && c == "=") begin emit_short(KIND_NE, "!", "="); mdl_mode = M_IDLE; end
        else begin
          push_item(KIND_NONE, ERR_LONE_BANG, '0, 0, 0, 1'b1); again = 1'b1;
        end
      M_EQ:
        if (!eot && c == "=") begin emit_short(KIND_EQEQ, "=", "="); mdl_mode = M_IDLE; end
        else begin emit_short(KIND_ASSIGN, "=", 0); again = 1'b1; end
      default: again = 1'b1;
    endcase
    if (again) start_token(c, eot);
  endfunction

  // Stimulus helpers.
  task automatic queue_text(string s);
    src_byte_t b;
    for (int i = 0; i < s.len(); i++) begin
      b.ch = s[i]; b.eot = 1'b0; b.hold = 1'b0;
      pending_bytes.push_back(b);
    end
  endtask

  task automatic queue_byte(logic [7:0] c, bit eot, bit hold);
    src_byte_t b;
    b.ch = c; b.eot = eot; b.hold = hold;
    pending_bytes.push_back(b);
  endtask

  function automatic string rand_word(int n);
    string s, pool;
    pool = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ_0123456789";
    s = "";
    for (int i = 0; i < n; i++)
      s = {s, string'(pool[(i == 0) ? $urandom_range(52, 0) : $urandom_range(62, 0)])};
    return s;
  endfunction

  task automatic queue_random_token();
    string kw[13] = '{"main", "int", "char", "const", "void", "if", "else", "do", "while",
                      "for", "scanf", "printf", "return"};
    string ops[22] = '{"+", "-", "*", "/", "<", "<=", ">", ">=", "!=", "==", "=", "(", ")",
                       "[", "]", "{", "}", ",", ";", "!", "@", "#"};
    string s;
    int n;
    case ($urandom_range(9, 0))
      0: queue_text(kw[$urandom_range(12, 0)]);
      1: queue_text(rand_word(($urandom_range(9, 0) == 0) ? $urandom_range(40, 20)
                                                          : $urandom_range(8, 1)));
      2: begin
        s = $sformatf("%0d", $urandom_range(99999, 1));
        if ($urandom_range(5, 0) == 0) s = {s, "x"};
        queue_text(($urandom_range(6, 0) == 0) ? {"0", s} : s);
      end
      3: queue_text(ops[$urandom_range(21, 0)]);
      4: begin
        s = "'";
        s = {s, rand_word(1)};
        if ($urandom_range(3, 0) != 0) s = {s, "'"};
        queue_text(s);
      end
      5: begin
        n = $urandom_range(12, 0);
        queue_byte("\"", 1'b0, 1'b0);
        for (int i = 0; i < n; i++) queue_byte($urandom_range(126, 32) == "\"" ? "a" :
                                               8'($urandom_range(126, 32)), 1'b0, 1'b0);
        if ($urandom_range(7, 0) == 0) queue_byte(8'($urandom_range(31, 1)), 1'b0, 1'b0);
        if ($urandom_range(7, 0) != 0) queue_byte("\"", 1'b0, 1'b0);
      end
      6: queue_byte(8'($urandom_range(255, 0)), $urandom_range(1, 0), 1'b0);
      7: queue_text("0");
      default: ;
    endcase
    // Separator: usually a blank, sometimes nothing so tokens abut.
    case ($urandom_range(5, 0))
      0: ;
      1: queue_byte("\t", 1'b0, 1'b0);
      2: queue_byte("\n", 1'b0, 1'b0);
      default: queue_byte(" ", 1'b0, 1'b0);
    endcase
  endtask

  initial begin
    // Directed part: extremes, every operator family and each special case.
    queue_text("main int char const void if else do while for scanf printf return ");
    queue_text("x_1 0 007 12ab 9 'a' '+' '' 'b? \"\" \"hi\" ");
    queue_byte("\"", 1'b0, 1'b0); queue_byte(8'd255, 1'b0, 1'b0); queue_text("zz\" ");
    queue_text("<<=>>=!=!x===;,(){}[]+-*/@ ");
    queue_text("abcdefghijklmnopqrstuvwxyzABCDEFGHIJKL ");
    queue_text("\"unterminated"); queue_byte(8'h00, 1'b1, 1'b0);
    queue_text("tail"); queue_byte(8'hFF, 1'b1, 1'b0);
    queue_byte(8'h00, 1'b0, 1'b1);
    // Random part.
    while (pending_bytes.size() < 270) queue_random_token();
    queue_byte(" ", 1'b1, 1'b1);
    while (pending_bytes.size() < 330) queue_random_token();
    queue_byte(8'h00, 1'b1, 1'b0);
  end

  int src_gap = 0, snk_gap = 0;
  bit reset_done = 1'b0;

  // Driver: presents bytes from the pending queue with random gaps.
  always @(posedge clk_i) begin
    if (reset_done) begin
      if (s_axis_tvalid && s_axis_tready) begin
        scan_byte(s_axis_tdata, s_axis_tlast);
        bytes_sent++;
        void'(pending_bytes.pop_front());
      end
      quiet_phase <= (pending_bytes.size() < 60);
      if (src_gap > 0) begin
        src_gap <= src_gap - 1;
        s_axis_tvalid <= 1'b0;
      end else if (!(s_axis_tvalid && !s_axis_tready) || !s_axis_tvalid) begin
        if (pending_bytes.size() == 0) begin
          s_axis_tvalid <= 1'b0;
        end else begin
          src_byte_t nb;
          nb = pending_bytes[0];
          if (nb.hold && expected_tokens.size() != 0) begin
            s_axis_tvalid <= 1'b0;
          end else if (!quiet_phase && $urandom_range(9, 0) == 0) begin
            s_axis_tvalid <= 1'b0;
            src_gap <= $urandom_range(5, 0);
          end else begin
            s_axis_tvalid <= 1'b1;
            s_axis_tdata <= nb.ch;
            s_axis_tlast <= nb.eot;
          end
        end
      end
    end
  end

  // Monitor: checks each accepted token item against the oldest prediction.
  always @(posedge clk_i) begin
    tok_item_t got, want;
    if (reset_done) begin
      if (m_axis_tvalid && m_axis_tready) begin
        got.kind = m_axis_tuser; got.err = m_axis_tdata[3:0];
        got.chunk = m_axis_tdata[67:4]; got.nbytes = m_axis_tdata[71:68];
        got.idx = m_axis_tdata[73:72]; got.last = m_axis_tlast;
        tokens_seen++;
        if (expected_tokens.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected token item %p", got);
        end else begin
          want = expected_tokens.pop_front();
          if (got !== want) begin
            mismatches++;
            if (mismatches <= 10) $display("token mismatch: expected %p, got %p", want, got);
          end
        end
      end
      if (snk_gap > 0) begin
        snk_gap <= snk_gap - 1;
        m_axis_tready <= 1'b0;
      end else if (!quiet_phase && $urandom_range(7, 0) == 0) begin
        m_axis_tready <= 1'b0;
        snk_gap <= $urandom_range(5, 0);
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // Watchdog on cycles with no accepted request on either side.
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WatchLimit) begin
      $display("watchdog expired with %0d items outstanding", expected_tokens.size());
      $display("status: fail");
      $finish;
    end
  end

  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    reset_done <= 1'b1;
    wait (pending_bytes.size() == 0 && expected_tokens.size() == 0);
    repeat (50) @(posedge clk_i);
    $display("Sent %0d source bytes and checked %0d token items, %0d mismatches.",
             bytes_sent, tokens_seen, mismatches);
    if (mismatches == 0 && expected_tokens.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

[files.f]
src/ctok_pkg.sv
src/ctok_fifo.sv
src/ctok_front.sv
src/ctok_back.sv
src/c_subset_tokenizer.sv
tb/sv/tb_c_subset_tokenizer.sv
